[design/esc_pkg.sv]
// ----------------------------------------------------------------------------
// Elevator sweep controller package
// Shared types and constants for the elevator sweep controller.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned FloorsDefault = 8;
  localparam int unsigned FloorFieldW   = 4;
  localparam int unsigned ActionW       = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE   = 3'd0,
    ACT_ARRIVE = 3'd1,
    ACT_UP     = 3'd2,
    ACT_DOWN   = 3'd3,
    ACT_IDLE   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    MOT_NONE     = 2'd0,
    MOT_MOVING   = 2'd1,
    MOT_ARRIVING = 2'd2
  } motion_e;

  typedef struct packed {
    logic    busy;
    motion_e motion;
    logic    heading;
  } ctrl_t;

endpackage

[design/esc_step.sv]
// ----------------------------------------------------------------------------
// Elevator sweep controller step logic
// Files a floor request into the stop bitmaps and evaluates one scheduling
// step, giving the next controller state and the action of this item.
// ----------------------------------------------------------------------------
module esc_step import esc_pkg::*; #(
  parameter int unsigned FLOORS = FloorsDefault,
  localparam int unsigned FW    = $clog2(FLOORS + 1)
) (
  input  logic                   cmd_i,
  input  logic [FloorFieldW-1:0] floor_i,
  input  ctrl_t                  ctrl_i,
  input  logic [FW-1:0]          now_i,
  input  logic [FLOORS-1:0]      this_i,
  input  logic [FLOORS-1:0]      next_i,
  output ctrl_t                  ctrl_o,
  output logic [FW-1:0]          now_o,
  output logic [FLOORS-1:0]      this_o,
  output logic [FLOORS-1:0]      next_o,
  output action_e                action_o
);

  localparam int unsigned CW = (FW > FloorFieldW) ? FW : FloorFieldW;
  localparam logic [CW-1:0] TopFloor = CW'(FLOORS);

  logic [CW-1:0]     req_floor;
  logic [CW-1:0]     cab_floor;
  logic              in_range;
  logic              do_file;
  logic              run;
  logic              hd_file;
  logic [FLOORS-1:0] req_bit;
  logic [FLOORS-1:0] this_file;
  logic [FLOORS-1:0] next_file;
  logic [FW-1:0]     now_move;
  logic [FLOORS-1:0] here_bit;
  logic [FLOORS-1:0] this_clr;
  logic              arrive;
  logic              swap;
  logic              go_idle;

  assign req_floor = CW'(floor_i);
  assign cab_floor = CW'(now_i);
  assign in_range  = (req_floor != '0) && (req_floor <= TopFloor);
  assign do_file   = !cmd_i && in_range;
  assign run       = cmd_i || (do_file && !ctrl_i.busy);
  assign req_bit   = FLOORS'(1) << (req_floor - CW'(1));

  always_comb begin
    hd_file   = ctrl_i.heading;
    this_file = this_i;
    next_file = next_i;
    if (do_file) begin
      if (ctrl_i.motion == MOT_NONE) begin
        hd_file = (req_floor > cab_floor);
      end
      if ((hd_file && (req_floor > cab_floor)) || (!hd_file && (req_floor < cab_floor))) begin
        this_file = this_i | req_bit;
      end else if (req_floor != cab_floor) begin
        next_file = next_i | req_bit;
      end else if (ctrl_i.motion != MOT_MOVING) begin
        this_file = this_i | req_bit;
      end
    end
  end

  always_comb begin
    now_move = now_i;
    if (ctrl_i.motion == MOT_MOVING) begin
      if (hd_file) begin
        if (CW'(now_i) < TopFloor) begin
          now_move = now_i + FW'(1);
        end
      end else if (now_i > FW'(1)) begin
        now_move = now_i - FW'(1);
      end
    end
  end

  assign here_bit = FLOORS'(1) << (now_move - FW'(1));
  assign arrive   = (|(this_file & here_bit)) &&
                    ((ctrl_i.motion == MOT_MOVING) || (ctrl_i.motion == MOT_NONE));
  assign this_clr = this_file & ~here_bit;
  assign swap     = !arrive && (ctrl_i.motion == MOT_ARRIVING) &&
                    (this_clr == '0) && (next_file != '0);
  assign go_idle  = !arrive && (ctrl_i.motion == MOT_ARRIVING) &&
                    (this_clr == '0) && (next_file == '0);

  // Next state.
  always_comb begin
    ctrl_o.busy    = ctrl_i.busy;
    ctrl_o.motion  = ctrl_i.motion;
    ctrl_o.heading = hd_file;
    now_o          = now_i;
    this_o         = this_file;
    next_o         = next_file;
    if (run) begin
      ctrl_o.busy = 1'b1;
      now_o       = now_move;
      if (arrive) begin
        ctrl_o.motion = MOT_ARRIVING;
      end else if (go_idle) begin
        ctrl_o.busy   = 1'b0;
        ctrl_o.motion = MOT_NONE;
        this_o        = this_clr;
      end else if (swap) begin
        ctrl_o.motion  = MOT_MOVING;
        ctrl_o.heading = !hd_file;
        this_o         = next_file;
        next_o         = '0;
      end else begin
        ctrl_o.motion = MOT_MOVING;
        if (ctrl_i.motion == MOT_ARRIVING) begin
          this_o = this_clr;
        end
      end
    end
  end

  // Action of this item.
  always_comb begin
    action_o = ACT_NONE;
    if (run) begin
      priority if (arrive) begin
        action_o = ACT_ARRIVE;
      end else if (go_idle) begin
        action_o = ACT_IDLE;
      end else if (swap) begin
        action_o = hd_file ? ACT_DOWN : ACT_UP;
      end else begin
        action_o = hd_file ? ACT_UP : ACT_DOWN;
      end
    end
  end

endmodule

[design/elevator_sweep_controller_top.sv]
// ----------------------------------------------------------------------------
// Elevator sweep controller
// LOOK scheduler that takes floor requests and step events and reports the
// cabin action, floor and direction for every item.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   command_i, floor_i
// result    out_valid_o / out_stall_i action_o, cabin_floor_o, heading_up_o
//
// One item is taken per clock; its result appears in the result register on
// the next cycle. The state update is a single pass of logic after the input.
// The input stalls only while a result waits and the result side stalls.
// Reset puts the cabin at floor one, heading up, free, with no stops filed.
module elevator_sweep_controller_top import esc_pkg::*; #(
  parameter int unsigned FLOORS = FloorsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic [FloorFieldW-1:0] floor_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ActionW-1:0]     action_o,
  output logic [FloorFieldW-1:0] cabin_floor_o,
  output logic                   heading_up_o
);

  localparam int unsigned FW = $clog2(FLOORS + 1);

  ctrl_t             ctrl_q, ctrl_d;
  logic [FW-1:0]     now_q, now_d;
  logic [FLOORS-1:0] this_q, this_d;
  logic [FLOORS-1:0] next_q, next_d;
  action_e           action_d;
  logic              out_valid_q;
  action_e           action_q;
  logic [FW-1:0]     cabin_q;
  logic              heading_q;
  logic              accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  esc_step #(
    .FLOORS(FLOORS)
  ) u_step (
    .cmd_i   (command_i),
    .floor_i (floor_i),
    .ctrl_i  (ctrl_q),
    .now_i   (now_q),
    .this_i  (this_q),
    .next_i  (next_q),
    .ctrl_o  (ctrl_d),
    .now_o   (now_d),
    .this_o  (this_d),
    .next_o  (next_d),
    .action_o(action_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '{busy: 1'b0, motion: MOT_NONE, heading: 1'b1};
      now_q       <= FW'(1);
      this_q      <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_q      <= ctrl_d;
        now_q       <= now_d;
        this_q      <= this_d;
        next_q      <= next_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q  <= action_d;
      cabin_q   <= now_d;
      heading_q <= ctrl_d.heading;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign cabin_floor_o = FloorFieldW'(cabin_q);
  assign heading_up_o  = heading_q;

endmodule

[design/esc_checker.sv]
// ----------------------------------------------------------------------------
// Elevator sweep controller checker
// Port-level assertions for the elevator sweep controller, bound to the top.
// ----------------------------------------------------------------------------
module esc_checker import esc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   command_i,
  input logic [FloorFieldW-1:0] floor_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [ActionW-1:0]     action_o,
  input logic [FloorFieldW-1:0] cabin_floor_o,
  input logic                   heading_up_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("Accepted item gave no result in the next cycle.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("Input stalled while the result register was free.");

  a_floor_zero_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !command_i && (floor_i == '0))
      |=> (action_o == ACT_NONE))
    else $error("Request for floor zero produced an action.");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((action_o == ACT_NONE) || (action_o == ACT_ARRIVE) ||
                     (action_o == ACT_UP) || (action_o == ACT_DOWN) ||
                     (action_o == ACT_IDLE)))
    else $error("Result carries an undefined action code.");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(action_o) && $stable(cabin_floor_o) && $stable(heading_up_o)))
    else $error("Stalled result changed.");

endmodule

bind elevator_sweep_controller_top esc_checker u_esc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .command_i    (command_i),
  .floor_i      (floor_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .action_o     (action_o),
  .cabin_floor_o(cabin_floor_o),
  .heading_up_o (heading_up_o)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// Elevator sweep controller testbench
// Drives floor requests and step events into the controller and checks each
// result against a cycle-free LOOK scheduler kept in the bench. Directed
// walks cover ignored floors, filing rules and sweep reversal. The random
// traffic keeps the cabin out of the top and bottom overrun states, and the
// run ends by driving the cabin into the top floor overrun state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import esc_pkg::*;

  localparam int unsigned FLOORS         = FloorsDefault;
  localparam bit          CMD_REQUEST    = 1'b0;
  localparam bit          CMD_STEP       = 1'b1;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          DRAIN_CYCLES   = 10;

  typedef struct {
    action_e                act;
    logic [FloorFieldW-1:0] cab;
    logic                   hd;
  } esc_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic                   command_i   = 1'b0;
  logic [FloorFieldW-1:0] floor_i     = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ActionW-1:0]     action_o;
  logic [FloorFieldW-1:0] cabin_floor_o;
  logic                   heading_up_o;

  logic [FloorFieldW-1:0] car_floor;
  bit                     car_busy;
  motion_e                car_motion;
  bit                     car_heading;
  logic [FLOORS-1:0]      stops_now;
  logic [FLOORS-1:0]      stops_later;

  esc_result_t            want_q[$];
  int                     fail_count   = 0;
  int                     quiet_cycles = 0;
  int unsigned            src_idle_pct  = 0;
  int unsigned            sink_stall_pct = 0;

  elevator_sweep_controller_top #(.FLOORS(FLOORS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .floor_i      (floor_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .cabin_floor_o(cabin_floor_o),
    .heading_up_o (heading_up_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic action_e step_car();
    car_busy = 1'b1;
    if (car_motion == MOT_MOVING) begin
      if (car_heading) begin
        if (car_floor < FLOORS) car_floor = car_floor + 1'b1;
      end else if (car_floor > 1) begin
        car_floor = car_floor - 1'b1;
      end
    end
    if (stops_now[car_floor - 1] &&
        (car_motion == MOT_MOVING || car_motion == MOT_NONE)) begin
      car_motion = MOT_ARRIVING;
      return ACT_ARRIVE;
    end
    if (car_motion == MOT_ARRIVING) begin
      stops_now[car_floor - 1] = 1'b0;
      if (stops_now == '0 && stops_later != '0) begin
        stops_now   = stops_later;
        stops_later = '0;
        car_heading = ~car_heading;
      end else if (stops_now == '0) begin
        car_busy   = 1'b0;
        car_motion = MOT_NONE;
        return ACT_IDLE;
      end
    end
    car_motion = MOT_MOVING;
    return car_heading ? ACT_UP : ACT_DOWN;
  endfunction

  function automatic action_e file_request(logic [FloorFieldW-1:0] f);
    if (f < 1 || f > FLOORS) return ACT_NONE;
    if (car_motion == MOT_NONE) car_heading = (f > car_floor);
    if ((car_heading && f > car_floor) || (!car_heading && f < car_floor)) begin
      stops_now[f - 1] = 1'b1;
    end else if (f != car_floor) begin
      stops_later[f - 1] = 1'b1;
    end else if (car_motion != MOT_MOVING) begin
      stops_now[f - 1] = 1'b1;
    end
    if (!car_busy) return step_car();
    return ACT_NONE;
  endfunction

  function automatic esc_result_t predict_item(bit cmd, logic [FloorFieldW-1:0] f);
    esc_result_t res;
    res.act = cmd ? step_car() : file_request(f);
    res.cab = car_floor;
    res.hd  = car_heading;
    return res;
  endfunction

  task automatic send_item(input bit cmd, input logic [FloorFieldW-1:0] fl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    floor_i    <= fl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want_q.push_back(predict_item(cmd, fl));
  endtask

  task automatic drain_until_free();
    while (car_busy) send_item(CMD_STEP, 4'($urandom_range(15)));
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic test_ignored_floors();
    send_item(CMD_REQUEST, 4'd0);
    send_item(CMD_REQUEST, 4'd15);
    send_item(CMD_REQUEST, 4'(FLOORS + 1));
  endtask

  task automatic test_sweep_walkthrough();
    send_item(CMD_REQUEST, 4'd4);
    send_item(CMD_REQUEST, 4'd3);
    send_item(CMD_STEP, 4'd15);
    send_item(CMD_REQUEST, 4'd1);
    send_item(CMD_REQUEST, 4'd2);
    send_item(CMD_STEP, 4'd0);
    send_item(CMD_REQUEST, 4'd3);
    drain_until_free();
    send_item(CMD_REQUEST, 4'd1);
    drain_until_free();
    send_item(CMD_REQUEST, 4'd5);
    drain_until_free();
    send_item(CMD_STEP, 4'd9);
    send_item(CMD_REQUEST, 4'd7);
    drain_until_free();
  endtask

  // A step while free starts an empty sweep, and the cabin then runs to the
  // end floor and stays there, so a floor ahead is requested right after it.
  task automatic test_random_traffic(input int count);
    logic [FloorFieldW-1:0] fl;
    int unsigned            r;
    bit                     at_end;
    for (int i = 0; i < count; i++) begin
      r      = $urandom_range(99);
      fl     = 4'($urandom_range(FLOORS, 1));
      at_end = car_heading ? (car_floor == FLOORS) : (car_floor == 1);
      if (car_motion == MOT_MOVING && stops_now == '0) begin
        fl = car_heading ? 4'($urandom_range(FLOORS, car_floor + 1)) :
                           4'($urandom_range(car_floor - 1, 1));
        send_item(CMD_REQUEST, fl);
      end else if (r < 12) begin
        fl = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, FLOORS + 1));
        send_item(CMD_REQUEST, fl);
      end else if (car_busy && r < 62) begin
        send_item(CMD_STEP, 4'($urandom_range(15)));
      end else if (!car_busy && r < 25 && !at_end) begin
        send_item(CMD_STEP, 4'($urandom_range(15)));
      end else begin
        send_item(CMD_REQUEST, fl);
      end
    end
  endtask

  // The cabin cannot leave the top floor once it overruns it, so this runs last.
  task automatic test_top_floor_overrun();
    if (car_motion == MOT_MOVING && stops_now == '0) begin
      send_item(CMD_REQUEST, car_heading ? 4'(FLOORS) : 4'd1);
    end
    drain_until_free();
    if (car_floor == FLOORS) begin
      send_item(CMD_REQUEST, 4'd1);
      drain_until_free();
    end
    send_item(CMD_REQUEST, 4'(FLOORS));
    drain_until_free();
    repeat (3) send_item(CMD_STEP, 4'd0);
    send_item(CMD_REQUEST, 4'd3);
    send_item(CMD_REQUEST, 4'(FLOORS));
    send_item(CMD_REQUEST, 4'd12);
    send_item(CMD_STEP, 4'd15);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    esc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_q.size() == 0) begin
        $error("result with no item pending: action %0d", action_o);
        fail_count++;
      end else begin
        want = want_q.pop_front();
        if (action_o !== want.act) begin
          $error("action: expected %0d, got %0d", want.act, action_o);
          fail_count++;
        end
        if (cabin_floor_o !== want.cab) begin
          $error("cabin_floor: expected %0d, got %0d", want.cab, cabin_floor_o);
          fail_count++;
        end
        if (heading_up_o !== want.hd) begin
          $error("heading_up: expected %0d, got %0d", want.hd, heading_up_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    car_floor   = 4'd1;
    car_busy    = 1'b0;
    car_motion  = MOT_NONE;
    car_heading = 1'b1;
    stops_now   = '0;
    stops_later = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idling(20, 49);
    test_ignored_floors();
    test_sweep_walkthrough();
    test_random_traffic(170);
    set_idling(49, 20);
    test_random_traffic(170);
    set_idling(0, 0);
    test_random_traffic(170);
    test_top_floor_overrun();

    in_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
